FILE: src/fmr_pkg.sv
// Shared types and constants of the delimiter message framer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package fmr_pkg;

    // Fixed field widths.
    localparam int LEN_W      = 11;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELIM_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELIM_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_SIZE    = 2'd2;

    // Configuration reset values.
    localparam logic [63:0]      RST_DELIM_BYTES = 64'd10;
    localparam logic [3:0]       RST_DELIM_LEN   = 4'd1;
    localparam logic [LEN_W-1:0] RST_MAX_SIZE    = 11'd1024;

    // End marker causes.
    localparam logic CAUSE_DELIMITER  = 1'b0;
    localparam logic CAUSE_SIZE_LIMIT = 1'b1;

    typedef struct packed {
        logic [63:0]      delim_bytes;
        logic [3:0]       delim_len;
        logic [LEN_W-1:0] max_size;
    } cfg_t;

    // What one received byte leaves for the emitter, apart from the window
    // snapshot and the flush count, whose widths follow the window depth.
    typedef struct packed {
        logic             push_valid;
        logic [7:0]       push_byte;
        logic             mark_valid;
        logic             mark_cause;
        logic [LEN_W-1:0] mark_len;
    } run_ctrl_t;

    typedef struct packed {
        logic [7:0]       msg_byte;
        logic             byte_valid;
        logic             end_of_message;
        logic             end_cause;
        logic [LEN_W-1:0] message_length;
        logic             last_of_run;
    } out_item_t;

endpackage

`default_nettype wire

FILE: src/fmr_frame_logic.sv
// Framing state (tail window, fill, length count) and its single-pass update.
// Depends on fmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmr_frame_logic #(
    parameter int MAX_DELIM_BYTES = 8,
    parameter int MAX_MSG_BYTES   = 1024,
    localparam int CNT_W = $clog2(MAX_DELIM_BYTES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fmr_pkg::cfg_t     cfg,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    output fmr_pkg::run_ctrl_t run,
    output logic [7:0]        window [MAX_DELIM_BYTES],
    output logic [CNT_W-1:0]  flush_count
);
    import fmr_pkg::*;

    localparam int IDX_W = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;

    logic [7:0]       win_reg  [MAX_DELIM_BYTES];
    logic [7:0]       win_next [MAX_DELIM_BYTES];
    logic [CNT_W-1:0] fill_reg, fill_next, fill_new;
    logic [LEN_W-1:0] count_reg, count_next, count_new;

    logic [CNT_W-1:0] dl;
    logic [LEN_W-1:0] mx;
    logic             push_out;
    logic             match;
    logic             size_hit;
    logic [LEN_W-1:0] delim_msg_len;
    logic [CNT_W-1:0] pos;
    logic [7:0]       delim_byte;

    // Effective delimiter length and size limit.
    always_comb
    begin
        if (cfg.delim_len == 4'd0)
            dl = CNT_W'(1);
        else if (32'(cfg.delim_len) > 32'(MAX_DELIM_BYTES))
            dl = CNT_W'(MAX_DELIM_BYTES);
        else
            dl = CNT_W'(cfg.delim_len);

        if (cfg.max_size == '0)
            mx = LEN_W'(1);
        else if (32'(cfg.max_size) > 32'(MAX_MSG_BYTES))
            mx = LEN_W'(MAX_MSG_BYTES);
        else
            mx = cfg.max_size;
    end

    // Window shift: a full window pushes out its oldest byte.
    always_comb
    begin
        push_out = (fill_reg >= dl) || (fill_reg == CNT_W'(MAX_DELIM_BYTES));
        for (int j = 0; j < MAX_DELIM_BYTES; j++)
        begin
            win_next[j] = win_reg[j];
            if (push_out)
            begin
                if (CNT_W'(j + 1) < fill_reg)
                    win_next[j] = win_reg[j + 1 < MAX_DELIM_BYTES ? j + 1 : j];
                else if (CNT_W'(j + 1) == fill_reg)
                    win_next[j] = rx_byte;
            end
            else if (CNT_W'(j) == fill_reg)
            begin
                win_next[j] = rx_byte;
            end
        end
        fill_new = push_out ? fill_reg : fill_reg + CNT_W'(1);
        if (32'(count_reg) < 32'(MAX_MSG_BYTES))
            count_new = count_reg + LEN_W'(1);
        else
            count_new = count_reg;
    end

    // Compare the newest bytes with the delimiter, newest byte first.
    always_comb
    begin
        match = (fill_new >= dl) && (count_new >= LEN_W'(dl));
        for (int i = 0; i < MAX_DELIM_BYTES; i++)
        begin
            pos        = fill_new - CNT_W'(1) - CNT_W'(i);
            delim_byte = 8'(cfg.delim_bytes >> (8 * i));
            if ((CNT_W'(i) < dl) && (win_next[pos[IDX_W-1:0]] != delim_byte))
                match = 1'b0;
        end
        size_hit      = !match && (count_new >= mx);
        delim_msg_len = count_new - LEN_W'(dl);
    end

    always_comb
    begin
        run.push_valid = push_out;
        run.push_byte  = win_reg[0];
        if (match)
        begin
            flush_count    = fill_new - dl;
            run.mark_valid = (delim_msg_len != '0);
            run.mark_cause = CAUSE_DELIMITER;
            run.mark_len   = delim_msg_len;
        end
        else if (size_hit)
        begin
            flush_count    = fill_new;
            run.mark_valid = 1'b1;
            run.mark_cause = CAUSE_SIZE_LIMIT;
            run.mark_len   = count_new;
        end
        else
        begin
            flush_count    = '0;
            run.mark_valid = 1'b0;
            run.mark_cause = CAUSE_DELIMITER;
            run.mark_len   = '0;
        end
        window = win_next;
        fill_next  = (match || size_hit) ? '0 : fill_new;
        count_next = (match || size_hit) ? '0 : count_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            for (int j = 0; j < MAX_DELIM_BYTES; j++)
                win_reg[j] <= '0;
        end
        else if (fire)
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
            win_reg   <= win_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/fmr_emitter.sv
// Result sequencer: holds the run left by one byte and issues its results
// one per cycle into the output register, unless a stall holds that register. Depends on fmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmr_emitter #(
    parameter int MAX_DELIM_BYTES = 8,
    localparam int CNT_W = $clog2(MAX_DELIM_BYTES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  fmr_pkg::run_ctrl_t run,
    input  logic [7:0]         window [MAX_DELIM_BYTES],
    input  logic [CNT_W-1:0]   flush_count,
    output logic               load_ok,
    output logic               out_valid,
    input  logic               out_stall,
    output fmr_pkg::out_item_t out_item
);
    import fmr_pkg::*;

    localparam int IDX_W = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;

    logic [7:0]       win_reg [MAX_DELIM_BYTES];
    logic             push_pend_reg;
    logic [7:0]       push_byte_reg;
    logic             mark_pend_reg;
    logic             mark_cause_reg;
    logic [LEN_W-1:0] mark_len_reg;
    logic [CNT_W-1:0] flush_idx_reg;
    logic [CNT_W-1:0] flush_cnt_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic      flush_more;
    logic      pending;
    logic      issue;
    out_item_t sel_item;

    assign flush_more = (flush_idx_reg < flush_cnt_reg);
    assign pending    = push_pend_reg || flush_more || mark_pend_reg;
    assign issue      = pending && (!out_valid_reg || !out_stall);
    assign load_ok    = !pending || (issue && sel_item.last_of_run);

    always_comb
    begin
        sel_item                = '0;
        if (push_pend_reg)
        begin
            sel_item.msg_byte    = push_byte_reg;
            sel_item.byte_valid  = 1'b1;
            sel_item.last_of_run = (flush_idx_reg == flush_cnt_reg) && !mark_pend_reg;
        end
        else if (flush_more)
        begin
            sel_item.msg_byte    = win_reg[flush_idx_reg[IDX_W-1:0]];
            sel_item.byte_valid  = 1'b1;
            sel_item.last_of_run = (flush_idx_reg + CNT_W'(1) == flush_cnt_reg)
                                   && !mark_pend_reg;
        end
        else
        begin
            sel_item.end_of_message = 1'b1;
            sel_item.end_cause      = mark_cause_reg;
            sel_item.message_length = mark_len_reg;
            sel_item.last_of_run    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_pend_reg <= 1'b0;
            mark_pend_reg <= 1'b0;
            flush_idx_reg <= '0;
            flush_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                push_pend_reg <= run.push_valid;
                mark_pend_reg <= run.mark_valid;
                flush_idx_reg <= '0;
                flush_cnt_reg <= flush_count;
            end
            else if (issue)
            begin
                if (push_pend_reg)
                    push_pend_reg <= 1'b0;
                else if (flush_more)
                    flush_idx_reg <= flush_idx_reg + CNT_W'(1);
                else
                    mark_pend_reg <= 1'b0;
            end

            if (issue)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            push_byte_reg  <= run.push_byte;
            mark_cause_reg <= run.mark_cause;
            mark_len_reg   <= run.mark_len;
            win_reg        <= window;
        end
        if (issue)
            out_item_reg <= sel_item;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!pending || (issue && sel_item.last_of_run)))
        else $error("run loaded while the previous run still has results");

    a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flush_idx_reg <= flush_cnt_reg)
        else $error("flush index ran past the flush count");

    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.byte_valid != out_item_reg.end_of_message))
        else $error("result is neither a content byte nor an end marker");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.end_of_message) |-> out_item_reg.last_of_run)
        else $error("end marker not flagged as last of its run");
`endif

endmodule

`default_nettype wire

FILE: src/delimiter_message_framer_core.sv
// Top level of the delimiter message framer: configuration registers, input
// register, framing logic and result emitter. Depends on fmr_pkg,
// fmr_frame_logic and fmr_emitter.
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  --------------------------------------
//  config    in         cfg_write_en          cfg_index, cfg_data
//  input     in         in_valid / in_stall   rx_byte
//  output    out        out_valid / out_stall msg_byte, byte_valid, end_of_message,
//                                             end_cause, message_length, last_of_run
//
// A byte with several results holds the emitter until its last result issues, so
// the input takes one byte per cycle only while each byte gives at most one result
// and the output does not stall; a window flush gives up to MAX_DELIM_BYTES + 2
// results. A taken byte passes the input, run and output registers before its first
// result. Reset loads the configuration defaults and clears the tail window, fill
// and length count at once; no clearing pass follows. Output stalls hold the result
// register and, once the emitter has no room for a new run, stall the input in the
// same cycle.
`timescale 1ns / 1ps
`default_nettype none

module delimiter_message_framer_core #(
    parameter int MAX_DELIM_BYTES = 8,
    parameter int MAX_MSG_BYTES   = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [fmr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          msg_byte,
    output logic                                byte_valid,
    output logic                                end_of_message,
    output logic                                end_cause,
    output logic [fmr_pkg::LEN_W-1:0]           message_length,
    output logic                                last_of_run
);
    import fmr_pkg::*;

    localparam int CNT_W = $clog2(MAX_DELIM_BYTES + 1);

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;

    logic             proc_fire;
    logic             load_ok;
    run_ctrl_t        run;
    logic [7:0]       window [MAX_DELIM_BYTES];
    logic [CNT_W-1:0] flush_count;
    out_item_t        out_item;

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delim_bytes <= RST_DELIM_BYTES;
            cfg_reg.delim_len   <= RST_DELIM_LEN;
            cfg_reg.max_size    <= RST_MAX_SIZE;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_IDX_DELIM_BYTES: cfg_reg.delim_bytes <= cfg_data;
                CFG_IDX_DELIM_LEN:   cfg_reg.delim_len   <= cfg_data[3:0];
                CFG_IDX_MAX_SIZE:    cfg_reg.max_size    <= cfg_data[LEN_W-1:0];
                default:             ;
            endcase
        end
    end

    // The held byte is processed as soon as the emitter can take its run.
    // The input register refills whenever it is empty or being processed.
    assign proc_fire = in_valid_reg && load_ok;
    assign in_stall  = in_valid_reg && !proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_byte_reg <= rx_byte;
    end

    fmr_frame_logic #(
        .MAX_DELIM_BYTES (MAX_DELIM_BYTES),
        .MAX_MSG_BYTES   (MAX_MSG_BYTES)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .fire        (proc_fire),
        .rx_byte     (in_byte_reg),
        .run         (run),
        .window      (window),
        .flush_count (flush_count)
    );

    fmr_emitter #(
        .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (proc_fire),
        .run         (run),
        .window      (window),
        .flush_count (flush_count),
        .load_ok     (load_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    assign msg_byte       = out_item.msg_byte;
    assign byte_valid     = out_item.byte_valid;
    assign end_of_message = out_item.end_of_message;
    assign end_cause      = out_item.end_cause;
    assign message_length = out_item.message_length;
    assign last_of_run    = out_item.last_of_run;

endmodule

`default_nettype wire

FILE: sim/delimiter_message_framer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for delimiter_message_framer_core: directed framing cases, then
// randomly built messages under several idle and stall patterns. Depends on fmr_pkg and the RTL.

module delimiter_message_framer_core_tb;

    import fmr_pkg::*;

    localparam int WIN_DEPTH     = 8;
    localparam int MSG_CAP       = 1024;
    // An input byte can cause up to WIN_DEPTH + 2 results, which reach the output through the
    // input, run and output registers, so this margin covers any byte still in flight.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 50000;

    // Register index 3 has no register behind it; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte      = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [7:0]            msg_byte;
    logic                  byte_valid;
    logic                  end_of_message;
    logic                  end_cause;
    logic [LEN_W-1:0]      message_length;
    logic                  last_of_run;

    delimiter_message_framer_core #(
        .MAX_DELIM_BYTES(WIN_DEPTH),
        .MAX_MSG_BYTES  (MSG_CAP)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .msg_byte      (msg_byte),
        .byte_valid    (byte_valid),
        .end_of_message(end_of_message),
        .end_cause     (end_cause),
        .message_length(message_length),
        .last_of_run   (last_of_run)
    );

    always #4 clk = ~clk;

    // The testbench's own copy of the configuration registers, updated as each write lands.
    logic [63:0]      delim_pattern  = RST_DELIM_BYTES;
    logic [3:0]       delim_len_reg  = RST_DELIM_LEN;
    logic [LEN_W-1:0] size_limit_reg = RST_MAX_SIZE;

    // The framer state as predicted: the tail window (oldest byte at index 0), how many
    // window slots are filled, and the byte count of the message in progress.
    logic [7:0]  tail_buf [WIN_DEPTH];
    int unsigned tail_fill  = 0;
    int unsigned byte_count = 0;

    out_item_t   framed_q [$];     // results predicted but not yet seen at the output
    logic [7:0]  rx_q [$];         // bytes waiting to be offered as requests

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct    = 0;
    int          error_count  = 0;

    initial begin
        for (int k = 0; k < WIN_DEPTH; k++) tail_buf[k] = 8'h00;
    end

    // A delimiter length of zero behaves as one, and anything above the window depth is
    // clipped to the window depth.
    function automatic int unsigned eff_delim_len();
        if (delim_len_reg == 0) return 1;
        if (delim_len_reg > WIN_DEPTH) return WIN_DEPTH;
        return delim_len_reg;
    endfunction

    function automatic void add_result(logic [7:0] b, logic is_byte, logic eom, logic cause,
                                       logic [LEN_W-1:0] len);
        out_item_t it;
        it.msg_byte       = b;
        it.byte_valid     = is_byte;
        it.end_of_message = eom;
        it.end_cause      = cause;
        it.message_length = len;
        it.last_of_run    = 1'b0;
        framed_q.push_back(it);
    endfunction

    // Predicts every result that one received byte causes. The result order is fixed: first the
    // byte pushed out of a full window, then any window bytes being flushed (oldest first),
    // then the end marker. The last of these carries last_of_run.
    task automatic frame_rx_byte(input logic [7:0] b);
        int unsigned dlen;
        int unsigned limit;
        int unsigned base;
        int unsigned k;
        bit          hit;
        out_item_t   tail_item;
        dlen  = eff_delim_len();
        limit = (size_limit_reg == 0) ? 1 : ((size_limit_reg > MSG_CAP) ? MSG_CAP
                                                                         : size_limit_reg);
        base  = framed_q.size();

        // A full window pushes out its oldest byte as content. After the delimiter length has
        // been shrunk, the window keeps its surplus bytes and still counts as full.
        if (tail_fill >= dlen) begin
            add_result(tail_buf[0], 1'b1, 1'b0, 1'b0, '0);
            for (k = 1; k < tail_fill; k++) tail_buf[k-1] = tail_buf[k];
            tail_buf[tail_fill-1] = b;
        end
        else begin
            tail_buf[tail_fill] = b;
            tail_fill++;
        end
        if (byte_count < MSG_CAP) byte_count++;

        // The newest dlen bytes are compared with the delimiter, whose last byte sits in the
        // lowest bits of the register. There is no match until enough bytes have arrived.
        hit = (tail_fill >= dlen) && (byte_count >= dlen);
        for (k = 0; hit && k < dlen; k++) begin
            if (tail_buf[tail_fill-1-k] != delim_pattern[8*k +: 8]) hit = 1'b0;
        end

        // The delimiter takes priority over the size limit. A message with no content ends
        // without a marker.
        if (hit) begin
            for (k = 0; k + dlen < tail_fill; k++) add_result(tail_buf[k], 1'b1, 1'b0, 1'b0, '0);
            if (byte_count != dlen)
                add_result(8'h00, 1'b0, 1'b1, CAUSE_DELIMITER, LEN_W'(byte_count - dlen));
            tail_fill  = 0;
            byte_count = 0;
        end
        else if (byte_count >= limit) begin
            for (k = 0; k < tail_fill; k++) add_result(tail_buf[k], 1'b1, 1'b0, 1'b0, '0);
            add_result(8'h00, 1'b0, 1'b1, CAUSE_SIZE_LIMIT, LEN_W'(byte_count));
            tail_fill  = 0;
            byte_count = 0;
        end

        if (framed_q.size() > base) begin
            tail_item = framed_q.pop_back();
            tail_item.last_of_run = 1'b1;
            framed_q.push_back(tail_item);
        end
    endtask

    // Sender. A request stays on the port until it is taken. Only then, or while the port
    // is idle, does the sender decide on a new request or a gap.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall) begin
                frame_rx_byte(rx_byte);
                void'(rx_q.pop_front());
            end
            if (!(in_valid && in_stall)) begin
                if (rx_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_q[0];
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Receiver. It compares each result it takes with the oldest prediction and stalls at
    // random, whether or not a result is on offer.
    always @(posedge clk) begin : check_results
        out_item_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (framed_q.size() == 0) begin
                    $error("result with nothing expected: msg_byte %0h byte_valid %0b",
                           msg_byte, byte_valid);
                    error_count++;
                end
                else begin
                    want = framed_q.pop_front();
                    check_field("msg_byte",       16'(want.msg_byte),       16'(msg_byte));
                    check_field("byte_valid",     16'(want.byte_valid),     16'(byte_valid));
                    check_field("end_of_message", 16'(want.end_of_message), 16'(end_of_message));
                    check_field("end_cause",      16'(want.end_cause),      16'(end_cause));
                    check_field("message_length", 16'(want.message_length), 16'(message_length));
                    check_field("last_of_run",    16'(want.last_of_run),    16'(last_of_run));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_IDX_DELIM_BYTES: delim_pattern  = val;
            CFG_IDX_DELIM_LEN:   delim_len_reg  = val[3:0];
            CFG_IDX_MAX_SIZE:    size_limit_reg = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Queues n bytes, taking the most significant byte first.
    task automatic queue_bytes(input logic [63:0] bytes, input int unsigned n);
        for (int k = n; k > 0; k--) rx_q.push_back(bytes[8*(k-1) +: 8]);
    endtask

    // Builds well-formed messages with random content, mostly closed by the full delimiter.
    // Some are cut short partway through the delimiter, and a few are plain noise.
    task automatic queue_messages(input int unsigned n_items);
        int unsigned target;
        int unsigned len;
        int unsigned dlen;
        int unsigned kind;
        dlen   = eff_delim_len();
        target = rx_q.size() + n_items;
        while (rx_q.size() < target) begin
            kind = $urandom_range(99);
            len  = $urandom_range(12);
            for (int k = 0; k < len; k++) rx_q.push_back(8'($urandom));
            if (kind < 75)
                queue_bytes(delim_pattern, dlen);
            else if (kind < 90 && dlen > 1)
                queue_bytes(delim_pattern >> (8 * $urandom_range(1, dlen - 1)),
                            dlen - 1);
        end
    endtask

    task automatic random_config();
        write_reg(CFG_IDX_DELIM_BYTES, {$urandom, $urandom});
        if ($urandom_range(3) == 0) write_reg(CFG_IDX_DELIM_LEN, 64'($urandom_range(15)));
        else                        write_reg(CFG_IDX_DELIM_LEN, 64'($urandom_range(1, 4)));
        if ($urandom_range(3) == 0) write_reg(CFG_IDX_MAX_SIZE, 64'($urandom_range(2047)));
        else                        write_reg(CFG_IDX_MAX_SIZE, 64'($urandom_range(4, 24)));
    endtask

    // Waits until every queued byte has been taken and every predicted result has arrived.
    // It then allows a margin for a final byte that causes no result. Checks are made on the
    // falling edge so that they never race the clocked blocks.
    task automatic drain();
        int unsigned waited;
        waited = 0;
        @(negedge clk);
        while ((rx_q.size() != 0 || in_valid || framed_q.size() != 0) && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (framed_q.size() != 0) begin
            $error("%0d predicted results never arrived", framed_q.size());
            error_count++;
            framed_q.delete();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: a single line-feed delimiter. The leading delimiter closes an empty
        // message, so nothing comes out. The extreme byte values then form one real message.
        queue_bytes(64'h0A00_FF0A, 4);
        drain();

        // A two-byte delimiter with a size limit of three. The first message reaches the limit
        // on the same byte that completes the delimiter, and the delimiter wins. The second
        // runs into the limit and flushes its window.
        write_reg(CFG_IDX_DELIM_BYTES, 64'h0D0A);
        write_reg(CFG_IDX_DELIM_LEN, 64'd2);
        write_reg(CFG_IDX_MAX_SIZE, 64'd3);
        queue_bytes(64'h410D_0A41_4243, 6);
        drain();

        // Zero delimiter length and zero size limit both behave as one. Stray upper bits of
        // the write data are dropped. A write to the unused index is ignored.
        write_reg(CFG_IDX_DELIM_BYTES, 64'hFFEE_DDCC_BBAA_9988);
        write_reg(CFG_IDX_DELIM_LEN, 64'hFFFF_FFFF_FFFF_FFF0);
        write_reg(CFG_IDX_MAX_SIZE, 64'hFFFF_FFFF_FFFF_F800);
        write_reg(CFG_IDX_UNUSED, 64'h0000_0000_0000_0007);
        queue_bytes(64'h8812, 2);
        drain();

        // An oversized delimiter length clips to the full eight-byte delimiter, and an
        // oversized limit clips to the largest message.
        write_reg(CFG_IDX_DELIM_LEN, 64'h0000_0000_0000_000F);
        write_reg(CFG_IDX_MAX_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_bytes(64'h5A, 1);
        queue_bytes(delim_pattern, 8);
        drain();

        // The delimiter is shrunk while a message is in progress. The surplus window bytes
        // are kept and come out as content ahead of the end marker.
        write_reg(CFG_IDX_DELIM_BYTES, 64'h0102_0304);
        write_reg(CFG_IDX_DELIM_LEN, 64'd4);
        queue_bytes(64'h5566_7711_22, 5);
        drain();
        write_reg(CFG_IDX_DELIM_LEN, 64'd1);
        queue_bytes(64'h04, 1);
        drain();

        // Random phases, one per idle pattern. In each phase the sender stops halfway and
        // holds off until every predicted result has arrived.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 61; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 61; end
                default: begin send_gap_pct = 10; stall_pct = 10; end
            endcase
            random_config();
            queue_messages(12);
            drain();
            queue_messages(12);
            drain();
        end

        if (error_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
